[sv/tbpe_pkg.sv]
`default_nettype none

package tbpe_pkg;

  localparam int DUR_W  = 16;
  localparam int CNT_W  = 3;
  localparam int BYTE_W = 8;
  localparam int NBIT_W = 4;
  localparam int IDX_W  = 3;
  localparam int DATA_W = 64;
  localparam int PIDX_W = 2;

  localparam logic [CNT_W-1:0]  MAX_PULSES_PER_BIT = 3'd4;
  localparam logic [NBIT_W-1:0] BITS_PER_BYTE      = 4'd8;

  localparam logic [CNT_W-1:0]  RST_ZERO_CNT = 3'd2;
  localparam logic [CNT_W-1:0]  RST_ONE_CNT  = 3'd2;
  localparam logic [DATA_W-1:0] RST_ZERO_SEQ = 64'd56034135;
  localparam logic [DATA_W-1:0] RST_ONE_SEQ  = 64'd112068270;
  localparam logic [DUR_W-1:0]  RST_TAIL     = 16'd945;
  localparam logic              RST_INIT_LVL = 1'b0;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_ZERO_CNT = 3'd0,
    REG_ONE_CNT  = 3'd1,
    REG_ZERO_SEQ = 3'd2,
    REG_ONE_SEQ  = 3'd3,
    REG_TAIL     = 3'd4,
    REG_INIT_LVL = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [CNT_W-1:0]  zero_cnt;
    logic [CNT_W-1:0]  one_cnt;
    logic [DATA_W-1:0] zero_seq;
    logic [DATA_W-1:0] one_seq;
    logic [DUR_W-1:0]  tail;
    logic              init_lvl;
  } cfg_t;

  // one step of the sequencer towards the output stage
  typedef struct packed {
    logic             emit;
    logic             done;
    logic [DUR_W-1:0] dur;
    logic             lvl;
  } pulse_t;

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c);
    return (c > MAX_PULSES_PER_BIT) ? MAX_PULSES_PER_BIT : c;
  endfunction

endpackage

`default_nettype wire

[sv/tbpe_cfg.sv]
`default_nettype none

module tbpe_cfg import tbpe_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [DATA_W-1:0] cfg_data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.zero_cnt <= RST_ZERO_CNT;
      cfg.one_cnt  <= RST_ONE_CNT;
      cfg.zero_seq <= RST_ZERO_SEQ;
      cfg.one_seq  <= RST_ONE_SEQ;
      cfg.tail     <= RST_TAIL;
      cfg.init_lvl <= RST_INIT_LVL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ZERO_CNT: cfg.zero_cnt <= cfg_data[CNT_W-1:0];
        REG_ONE_CNT:  cfg.one_cnt  <= cfg_data[CNT_W-1:0];
        REG_ZERO_SEQ: cfg.zero_seq <= cfg_data;
        REG_ONE_SEQ:  cfg.one_seq  <= cfg_data;
        REG_TAIL:     cfg.tail     <= cfg_data[DUR_W-1:0];
        REG_INIT_LVL: cfg.init_lvl <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/tbpe_seq.sv]
`default_nettype none

module tbpe_seq import tbpe_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cfg_t              cfg,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BYTE_W-1:0] data_byte,
  input  wire logic [NBIT_W-1:0] bits_in_byte,
  input  wire logic              block_start,
  input  wire logic              block_end,
  input  wire logic              can_take,
  output pulse_t                 pulse
);

  logic              busy;
  logic              lead;
  logic              tail;
  logic              level;
  logic [BYTE_W-1:0] shreg;
  logic [NBIT_W-1:0] nleft;
  logic [PIDX_W-1:0] pidx;

  logic              accept;
  logic              step;
  logic [CNT_W-1:0]  cur_cnt;
  logic [DATA_W-1:0] cur_seq;
  logic              bit_end;

  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;
  assign step     = busy && can_take;

  // msb of the shift register is the bit on the line
  assign cur_cnt = clamp_count(shreg[BYTE_W-1] ? cfg.one_cnt : cfg.zero_cnt);
  assign cur_seq = shreg[BYTE_W-1] ? cfg.one_seq : cfg.zero_seq;
  assign bit_end = (cur_cnt == '0) || ({1'b0, pidx} == cur_cnt - CNT_W'(1));

  always_comb begin
    pulse.emit = 1'b0;
    pulse.done = 1'b0;
    pulse.dur  = '0;
    pulse.lvl  = level;
    if (step) begin
      if (lead) begin
        pulse.emit = 1'b1;
      end else if (nleft != '0) begin
        pulse.emit = (cur_cnt != '0);
        pulse.dur  = cur_seq[pidx*DUR_W +: DUR_W];
      end else if (tail) begin
        pulse.emit = 1'b1;
        pulse.dur  = cfg.tail;
      end else begin
        pulse.done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      lead  <= 1'b0;
      tail  <= 1'b0;
      level <= 1'b0;
      nleft <= '0;
      pidx  <= '0;
    end else if (accept) begin
      busy  <= 1'b1;
      shreg <= data_byte;
      nleft <= (bits_in_byte > BITS_PER_BYTE) ? BITS_PER_BYTE : bits_in_byte;
      lead  <= block_start && cfg.init_lvl;
      tail  <= block_end && (cfg.tail != '0);
      pidx  <= '0;
      if (block_start) begin
        level <= 1'b0;
      end
    end else if (step) begin
      if (lead) begin
        lead  <= 1'b0;
        level <= !level;
      end else if (nleft != '0) begin
        if (cur_cnt != '0) begin
          level <= !level;
        end
        if (bit_end) begin
          shreg <= {shreg[BYTE_W-2:0], 1'b0};
          nleft <= nleft - NBIT_W'(1);
          pidx  <= '0;
        end else begin
          pidx <= pidx + PIDX_W'(1);
        end
      end else if (tail) begin
        tail  <= 1'b0;
        level <= !level;
      end else begin
        busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[sv/tbpe_out.sv]
`default_nettype none

module tbpe_out import tbpe_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire pulse_t           pulse,
  output logic                  can_take,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [DUR_W-1:0]      pulse_duration,
  output logic                  start_level,
  output logic                  last_of_run
);

  // one pulse held back until it is known whether another follows
  logic             hold_valid;
  logic [DUR_W-1:0] hold_dur;
  logic             hold_lvl;

  assign can_take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (pulse.emit) begin
        hold_valid <= 1'b1;
        hold_dur   <= pulse.dur;
        hold_lvl   <= pulse.lvl;
      end else if (pulse.done) begin
        hold_valid <= 1'b0;
      end
      if ((pulse.emit || pulse.done) && hold_valid) begin
        out_valid      <= 1'b1;
        pulse_duration <= hold_dur;
        start_level    <= hold_lvl;
        last_of_run    <= pulse.done;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[sv/tape_bits_to_pulses_encoder_unit.sv]
`default_nettype none

// Tape bit-to-pulse encoder. Each input transaction carries one data byte, the
// number of its leading bits to send (values above 8 count as 8) and block
// start/end flags. Bits go out msb first; a zero bit gives zero_pulse_count
// pulses from zero_sequence, a one bit one_pulse_count pulses from
// one_sequence (counts above 4 count as 4). Every pulse reports the line level
// at its start and the level flips after it. block_start reloads the level from
// initial_level and, when that is high, opens with a zero-length pulse;
// block_end adds a tail pulse when tail_duration is nonzero. last_of_run marks
// the final pulse of a byte; a byte that yields no pulse yields no output.
// Timing: the byte is walked bit by bit through a shift register, one pulse or
// one skipped zero-count bit per cycle, and the next byte is accepted only
// once the walk, lead and tail pulses included, has ended; a stalled output
// pauses the walk. Configuration is written through cfg_we/cfg_index/
// cfg_data, indexes 0 to 5 for zero count, one count, zero sequence, one
// sequence, tail and initial level, and must only change while idle.

module tape_bits_to_pulses_encoder_unit import tbpe_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration write port
  input  wire logic              cfg_we,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [DATA_W-1:0] cfg_data,
  // byte channel
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BYTE_W-1:0] data_byte,
  input  wire logic [NBIT_W-1:0] bits_in_byte,
  input  wire logic              block_start,
  input  wire logic              block_end,
  // pulse channel
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [DUR_W-1:0]       pulse_duration,
  output logic                   start_level,
  output logic                   last_of_run
);

  cfg_t   cfg;
  pulse_t pulse;
  logic   can_take;

  // register file, reset to the default pulse timings
  tbpe_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // bit-serial walker: lead pulse, data bits msb first, then tail;
  // owns the line level that carries over between transactions
  tbpe_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .bits_in_byte (bits_in_byte),
    .block_start  (block_start),
    .block_end    (block_end),
    .can_take     (can_take),
    .pulse        (pulse)
  );

  // holding stage plus output register; the held pulse is released when the
  // next pulse or the end of the byte arrives, with last_of_run at the end
  tbpe_out u_out (
    .clk            (clk),
    .rst            (rst),
    .pulse          (pulse),
    .can_take       (can_take),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pulse_duration (pulse_duration),
    .start_level    (start_level),
    .last_of_run    (last_of_run)
  );

endmodule

`default_nettype wire

[sv/tbpe_checker.sv]
`default_nettype none

module tbpe_checker import tbpe_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [DUR_W-1:0] pulse_duration,
  input wire logic             start_level,
  input wire logic             last_of_run
);

  // a stalled pulse holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pulse_duration)
      && $stable(start_level) && $stable(last_of_run))
    else $error("pulse changed while stalled");

  // nothing is offered straight after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("pulse offered after reset");

  // one byte at a time
  a_one_byte: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second byte taken while busy");

  // once idle, any pulse still waiting closes its run
  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    in_ready && out_valid |-> last_of_run)
    else $error("idle with an unfinished run");

endmodule

bind tape_bits_to_pulses_encoder_unit tbpe_checker u_tbpe_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .pulse_duration (pulse_duration),
  .start_level    (start_level),
  .last_of_run    (last_of_run)
);

`default_nettype wire

[tb/sv/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tbpe_pkg::*;

  // cycles with no transaction on either channel before the run is abandoned
  localparam int STALL_LIMIT = 3000;
  // settling time for a byte that yields no pulse
  localparam int HOLD_OFF = 40;

  // one expected pulse on the output channel
  typedef struct {
    logic [DUR_W-1:0] dur;
    logic             lvl;
    logic             last;
  } pulse_exp_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] data_byte = '0;
  logic [NBIT_W-1:0] bits_in_byte = '0;
  logic              block_start = 1'b0;
  logic              block_end = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DUR_W-1:0]  pulse_duration;
  logic              start_level;
  logic              last_of_run;

  // encoder settings and line level as the predictor sees them
  cfg_t       enc_cfg;
  logic       model_level;
  int         run_len;
  pulse_exp_t pending_pulses[$];

  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  tape_bits_to_pulses_encoder_unit uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .bits_in_byte   (bits_in_byte),
    .block_start    (block_start),
    .block_end      (block_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pulse_duration (pulse_duration),
    .start_level    (start_level),
    .last_of_run    (last_of_run)
  );

  always #5 clk = ~clk;

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // queue one pulse at the current level, then flip the level
  function automatic void add_pulse(input logic [DUR_W-1:0] d);
    pending_pulses.push_back('{d, model_level, 1'b0});
    model_level = ~model_level;
    run_len++;
  endfunction

  // pulses caused by one accepted byte, the last one flagged
  function automatic void predict_pulses(input logic [BYTE_W-1:0] d, input logic [NBIT_W-1:0] n,
                                         input logic first, input logic closing);
    logic [BYTE_W-1:0] shreg;
    logic [NBIT_W-1:0] used;
    logic [CNT_W-1:0]  cnt;
    logic [DATA_W-1:0] seq;
    logic              is_one;
    int                tail_idx;
    shreg = d;
    run_len = 0;
    // more than a byte's worth of bits is cut back to eight
    used = (n > BITS_PER_BYTE) ? BITS_PER_BYTE : n;
    if (first) begin
      model_level = enc_cfg.init_lvl;
      // a high initial level opens with a zero-length pulse from a low line
      if (model_level) begin
        model_level = 1'b0;
        add_pulse('0);
      end
    end
    for (int b = 0; b < used; b++) begin
      is_one = shreg[BYTE_W-1];
      shreg = shreg << 1;
      seq = is_one ? enc_cfg.one_seq : enc_cfg.zero_seq;
      cnt = is_one ? enc_cfg.one_cnt : enc_cfg.zero_cnt;
      if (cnt > MAX_PULSES_PER_BIT) cnt = MAX_PULSES_PER_BIT;
      for (int p = 0; p < cnt; p++) add_pulse(seq[DUR_W*p +: DUR_W]);
    end
    if (closing && enc_cfg.tail != '0) add_pulse(enc_cfg.tail);
    if (run_len > 0) begin
      tail_idx = pending_pulses.size() - 1;
      pending_pulses[tail_idx].last = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // output checking
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    pulse_exp_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_pulses.size() == 0) begin
        $error("pulse with nothing expected: pulse_duration %0d start_level %0b",
               pulse_duration, start_level);
        mismatches++;
      end else begin
        want = pending_pulses.pop_front();
        if (pulse_duration !== want.dur) begin
          $error("pulse_duration: expected %0d, got %0d", want.dur, pulse_duration);
          mismatches++;
        end
        if (start_level !== want.lvl) begin
          $error("start_level: expected %0b, got %0b", want.lvl, start_level);
          mismatches++;
        end
        if (last_of_run !== want.last) begin
          $error("last_of_run: expected %0b, got %0b", want.last, last_of_run);
          mismatches++;
        end
      end
    end
  end

  // watchdog: any transaction on either side restarts the count
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // offer one byte; valid is only dropped when the sender really idles, so
  // back-to-back transactions never lower and raise it in the same step
  task automatic send_byte(input logic [BYTE_W-1:0] d, input logic [NBIT_W-1:0] n,
                           input logic first, input logic closing);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid     <= 1'b1;
    data_byte    <= d;
    bits_in_byte <= n;
    block_start  <= first;
    block_end    <= closing;
    do @(posedge clk); while (!in_ready);
    predict_pulses(d, n, first, closing);
  endtask

  // stop sending, let every pulse drain, then allow for a byte still being
  // walked that yields nothing
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (pending_pulses.size() != 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  // write all six registers on consecutive cycles; only called while idle
  task automatic apply_settings(input cfg_t s);
    cfg_reg_t          r;
    logic [DATA_W-1:0] v;
    for (int i = REG_ZERO_CNT; i <= REG_INIT_LVL; i++) begin
      r = cfg_reg_t'(i);
      case (r)
        REG_ZERO_CNT: v = DATA_W'(s.zero_cnt);
        REG_ONE_CNT:  v = DATA_W'(s.one_cnt);
        REG_ZERO_SEQ: v = s.zero_seq;
        REG_ONE_SEQ:  v = s.one_seq;
        REG_TAIL:     v = DATA_W'(s.tail);
        default:      v = DATA_W'(s.init_lvl);
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= r;
      cfg_data  <= v;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    enc_cfg = s;
  endtask

  function automatic cfg_t random_settings();
    cfg_t s;
    // counts mostly in the legal range, now and then above it
    s.zero_cnt = ($urandom_range(7) == 0) ? CNT_W'($urandom_range(5, 7))
                                         : CNT_W'($urandom_range(0, 4));
    s.one_cnt  = ($urandom_range(7) == 0) ? CNT_W'($urandom_range(5, 7))
                                         : CNT_W'($urandom_range(0, 4));
    s.zero_seq = {$urandom, $urandom};
    s.one_seq  = {$urandom, $urandom};
    s.tail     = ($urandom_range(3) == 0) ? '0 : DUR_W'($urandom);
    s.init_lvl = 1'($urandom_range(1));
    return s;
  endfunction

  // usually a whole byte, sometimes any count the field can hold
  function automatic logic [NBIT_W-1:0] random_bit_count();
    return ($urandom_range(9) < 7) ? BITS_PER_BYTE : NBIT_W'($urandom_range(0, 15));
  endfunction

  // well-formed blocks with random content, mixed with stray bytes whose
  // flags are random (missing ends, restarts, lone ends)
  task automatic random_blocks(input int count);
    int left;
    int len;
    left = count;
    while (left > 0) begin
      if ($urandom_range(9) == 0) begin
        send_byte(BYTE_W'($urandom), NBIT_W'($urandom_range(0, 15)),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
        left--;
      end else begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          send_byte(BYTE_W'($urandom), random_bit_count(), i == 0, i == len - 1);
        end
        left -= len;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // settings straight out of reset
  task automatic test_reset_settings();
    send_idle_pct  = 12;
    recv_stall_pct = 12;
    send_byte(8'hA5, 4'd8, 1'b1, 1'b1);
    send_byte(8'h00, 4'd8, 1'b1, 1'b0);
    send_byte(8'hFF, 4'd8, 1'b0, 1'b0);
    send_byte(8'h5A, 4'd4, 1'b0, 1'b1);
  endtask

  // field and register extremes, oversized counts, empty bytes, restarts
  task automatic test_extremes();
    settle_idle();
    // full count, clamped count, widest durations, high initial level
    apply_settings('{zero_cnt: MAX_PULSES_PER_BIT, one_cnt: 3'd7, zero_seq: '1,
                     one_seq: 64'h0000_FFFF_0001_8000, tail: '1, init_lvl: 1'b1});
    send_byte(8'h80, 4'd8, 1'b1, 1'b1);
    send_byte(8'h01, 4'd15, 1'b1, 1'b0);
    send_byte(8'hFF, 4'd0, 1'b0, 1'b0);
    send_byte(8'h7F, 4'd9, 1'b0, 1'b1);
    send_byte(8'hC3, 4'd1, 1'b1, 1'b1);
    // nothing at all comes out
    settle_idle();
    apply_settings('{zero_cnt: '0, one_cnt: '0, zero_seq: '0, one_seq: '0,
                     tail: '0, init_lvl: 1'b0});
    send_byte(8'hFF, 4'd8, 1'b1, 1'b1);
    send_byte(8'h00, 4'd8, 1'b0, 1'b0);
    // restart without closing, and a block made of the leading pulse only
    settle_idle();
    apply_settings('{zero_cnt: 3'd1, one_cnt: 3'd3, zero_seq: {$urandom, $urandom},
                     one_seq: {$urandom, $urandom}, tail: '0, init_lvl: 1'b1});
    send_byte(8'h0F, 4'd8, 1'b1, 1'b0);
    send_byte(8'hF0, 4'd8, 1'b1, 1'b0);
    send_byte(8'h00, 4'd0, 1'b1, 1'b1);
    send_byte(8'hAA, 4'd8, 1'b0, 1'b1);
    // zero bits silent, tail of one unit
    settle_idle();
    apply_settings('{zero_cnt: '0, one_cnt: MAX_PULSES_PER_BIT, zero_seq: {$urandom, $urandom},
                     one_seq: {$urandom, $urandom}, tail: 16'd1, init_lvl: 1'b0});
    send_byte(8'h00, 4'd8, 1'b1, 1'b1);
    send_byte(8'h81, 4'd8, 1'b0, 1'b0);
  endtask

  // random traffic under each idling pattern, fresh settings for each
  task automatic test_random_traffic();
    int idle_pcts[4]  = '{0, 85, 0, 12};
    int stall_pcts[4] = '{0, 0, 85, 12};
    for (int ph = 0; ph < 4; ph++) begin
      settle_idle();
      send_idle_pct  = idle_pcts[ph];
      recv_stall_pct = stall_pcts[ph];
      apply_settings(random_settings());
      random_blocks(20);
    end
  endtask

  // sender holds off until every pulse has been taken, then carries on
  task automatic test_drain_pause();
    settle_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 85;
    apply_settings(random_settings());
    random_blocks(6);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_pulses.size() != 0);
    random_blocks(6);
  endtask

  initial begin
    enc_cfg = '{zero_cnt: RST_ZERO_CNT, one_cnt: RST_ONE_CNT, zero_seq: RST_ZERO_SEQ,
                one_seq: RST_ONE_SEQ, tail: RST_TAIL, init_lvl: RST_INIT_LVL};
    model_level = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_settings();
    test_extremes();
    test_random_traffic();
    test_drain_pause();

    // everything accepted: drain and give the block time to fall quiet
    settle_idle();
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
sv/tbpe_pkg.sv
sv/tbpe_cfg.sv
sv/tbpe_seq.sv
sv/tbpe_out.sv
sv/tape_bits_to_pulses_encoder_unit.sv
sv/tbpe_checker.sv
tb/sv/testbench.sv
